/* sv/descriptor_nearest_neighbor_ratio_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the descriptor nearest neighbor ratio block
// Shared property templates, clocked on the rising edge, idle in reset.
// ----------------------------------------------------------------------------
`ifndef DESCRIPTOR_NEAREST_NEIGHBOR_RATIO_DEFINES_SVH
`define DESCRIPTOR_NEAREST_NEIGHBOR_RATIO_DEFINES_SVH

// Same-cycle implication.
`define DNNR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dnnr: same-cycle check failed");

// Next-cycle implication.
`define DNNR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dnnr: next-cycle check failed");

`endif

/* sv/dnnr_pkg.sv */
// ----------------------------------------------------------------------------
// dnnr_pkg
// Widths, constants and codes of the descriptor nearest neighbor ratio block.
// ----------------------------------------------------------------------------
`default_nettype none

package dnnr_pkg;

    localparam int ELEM_W     = 16;
    localparam int DIST_W     = 48;
    localparam int SQ_W       = 32;
    localparam int INDEX_W    = 16;
    localparam int LEN_W      = 8;
    localparam int MAX_LENGTH = 128;
    localparam int ADDR_W     = $clog2(MAX_LENGTH);

    localparam logic [LEN_W-1:0]  MIN_LEN       = LEN_W'(4);
    localparam logic [LEN_W-1:0]  MAX_LEN       = LEN_W'(MAX_LENGTH);
    localparam logic [LEN_W-1:0]  LEN_RESET     = LEN_W'(64);
    // 1e6 scaled by 2^28
    localparam logic [DIST_W-1:0] DIST_INIT     = 48'hF424_0000_0000;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    typedef enum logic {
        CMD_QUERY = 1'b0,
        CMD_MODEL = 1'b1
    } cmd_t;

endpackage

`default_nettype wire

/* sv/dnnr_ram.sv */
// ----------------------------------------------------------------------------
// dnnr_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module dnnr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* sv/descriptor_nearest_neighbor_ratio.sv */
// Result path: the final element passes the s1, s2, s3 and s4 registers before the result register shows it.
// Throughput: one element per cycle; a 5-stage pipeline (query RAM read, square,
// accumulate, best/second update, ratio test) stalls only while a result waits.
// Reset: descriptor_length returns to 64, the search state and counters clear;
// the query store keeps its contents and must be loaded before use.
`default_nettype none

module descriptor_nearest_neighbor_ratio (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [dnnr_pkg::LEN_W-1:0]      cfg_wr_data,   // descriptor_length
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [dnnr_pkg::S_TDATA_W-1:0]  s_tdata,       // [15:0] element_value, [16] sign_flag
    input  wire logic                            s_tuser,       // [0] cmd
    input  wire logic                            s_tlast,       // final_model
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [dnnr_pkg::M_TDATA_W-1:0]  m_tdata,       // [15:0] neighbor_index
    output logic                                 m_tuser        // [0] matched
);

    localparam int ELEM_W  = dnnr_pkg::ELEM_W;
    localparam int DIST_W  = dnnr_pkg::DIST_W;
    localparam int SQ_W    = dnnr_pkg::SQ_W;
    localparam int INDEX_W = dnnr_pkg::INDEX_W;
    localparam int LEN_W   = dnnr_pkg::LEN_W;
    localparam int ADDR_W  = dnnr_pkg::ADDR_W;

    // ---------------- configuration ----------------
    logic [LEN_W-1:0] len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= dnnr_pkg::LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            len_reg <= cfg_wr_data;
        end
    end

    // ---------------- stage 0: accept, element position ----------------
    logic                     adv;
    logic                     accept;
    dnnr_pkg::cmd_t           in_cmd;
    logic [LEN_W-1:0]         len_eff;
    logic [LEN_W-1:0]         pos;
    logic                     in_last;
    logic [ADDR_W-1:0]        elem_cnt_reg;
    logic [ADDR_W-1:0]        elem_cnt_next;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;
    assign in_cmd   = dnnr_pkg::cmd_t'(s_tuser);

    always_comb
    begin
        priority if (len_reg < dnnr_pkg::MIN_LEN)
            len_eff = dnnr_pkg::MIN_LEN;
        else if (len_reg > dnnr_pkg::MAX_LEN)
            len_eff = dnnr_pkg::MAX_LEN;
        else
            len_eff = len_reg;

        pos = ({1'b0, elem_cnt_reg} >= len_eff) ? '0 : {1'b0, elem_cnt_reg};
        in_last = (pos + LEN_W'(1)) >= len_eff;
        elem_cnt_next = in_last ? '0 : ADDR_W'(pos + LEN_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_cnt_reg <= '0;
        end
        else if (accept)
        begin
            elem_cnt_reg <= elem_cnt_next;
        end
    end

    logic [ELEM_W-1:0] q_rd_data;

    dnnr_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (dnnr_pkg::MAX_LENGTH)
    ) u_query_ram (
        .clk     (clk),
        .wr_en   (accept && (in_cmd == dnnr_pkg::CMD_QUERY)),
        .wr_addr (pos[ADDR_W-1:0]),
        .wr_data (s_tdata[ELEM_W-1:0]),
        .rd_en   (adv),
        .rd_addr (pos[ADDR_W-1:0]),
        .rd_data (q_rd_data)
    );

    // ---------------- stage 1: difference and square ----------------
    logic                      s1_valid_reg;
    dnnr_pkg::cmd_t            s1_cmd_reg;
    logic signed [ELEM_W-1:0]  s1_val_reg;
    logic                      s1_sign_reg;
    logic                      s1_final_reg;
    logic                      s1_last_reg;

    logic signed [ELEM_W:0]    diff;
    logic signed [2*ELEM_W+1:0] prod;

    assign diff = $signed({q_rd_data[ELEM_W-1], q_rd_data})
                - $signed({s1_val_reg[ELEM_W-1], s1_val_reg});
    assign prod = diff * diff;

    // ---------------- stage 2: accumulate ----------------
    logic                      s2_valid_reg;
    dnnr_pkg::cmd_t            s2_cmd_reg;
    logic                      s2_sign_reg;
    logic                      s2_final_reg;
    logic                      s2_last_reg;
    logic [SQ_W-1:0]           s2_sq_reg;

    logic [DIST_W-1:0]         partial_reg;
    logic [DIST_W-1:0]         partial_next;
    logic [DIST_W-1:0]         sum;

    assign sum = partial_reg + DIST_W'(s2_sq_reg);

    always_comb
    begin
        partial_next = partial_reg;
        if (s2_valid_reg)
        begin
            if (s2_cmd_reg == dnnr_pkg::CMD_QUERY || s2_last_reg)
                partial_next = '0;
            else
                partial_next = sum;
        end
    end

    // ---------------- stage 3: best and second-best update ----------------
    logic                      s3_valid_reg;
    logic                      s3_clear_reg;
    logic                      s3_sign_reg;
    logic                      s3_final_reg;
    logic [DIST_W-1:0]         s3_dist_reg;

    logic                      qsign_reg;
    logic                      qsign_next;
    logic [INDEX_W-1:0]        model_cnt_reg;
    logic [INDEX_W-1:0]        model_cnt_next;
    logic [DIST_W-1:0]         best_reg;
    logic [DIST_W-1:0]         best_next;
    logic [DIST_W-1:0]         second_reg;
    logic [DIST_W-1:0]         second_next;
    logic [INDEX_W-1:0]        best_pos_reg;
    logic [INDEX_W-1:0]        best_pos_next;

    logic [DIST_W-1:0]         upd_best;
    logic [DIST_W-1:0]         upd_second;
    logic [INDEX_W-1:0]        upd_pos;
    logic                      res_load;

    always_comb
    begin
        upd_best   = best_reg;
        upd_second = second_reg;
        upd_pos    = best_pos_reg;
        if (s3_sign_reg == qsign_reg)
        begin
            if (s3_dist_reg < best_reg)
            begin
                upd_second = best_reg;
                upd_best   = s3_dist_reg;
                upd_pos    = model_cnt_reg;
            end
            else if (s3_dist_reg < second_reg)
            begin
                upd_second = s3_dist_reg;
            end
        end

        qsign_next     = qsign_reg;
        model_cnt_next = model_cnt_reg;
        best_next      = best_reg;
        second_next    = second_reg;
        best_pos_next  = best_pos_reg;
        res_load       = 1'b0;

        if (s3_valid_reg)
        begin
            if (s3_clear_reg || s3_final_reg)
            begin
                // query load or end of set: restart the search
                model_cnt_next = '0;
                best_next      = dnnr_pkg::DIST_INIT;
                second_next    = dnnr_pkg::DIST_INIT;
                best_pos_next  = '0;
                if (s3_clear_reg)
                    qsign_next = s3_sign_reg;
                else
                    res_load = 1'b1;
            end
            else
            begin
                model_cnt_next = model_cnt_reg + INDEX_W'(1);
                best_next      = upd_best;
                second_next    = upd_second;
                best_pos_next  = upd_pos;
            end
        end
    end

    // ---------------- stage 4: ratio test ----------------
    logic                      s4_valid_reg;
    logic [DIST_W-1:0]         s4_best_reg;
    logic [DIST_W-1:0]         s4_second_reg;
    logic [INDEX_W-1:0]        s4_pos_reg;

    logic [DIST_W+2:0]         best_x5;
    logic [DIST_W+2:0]         second_x3;
    logic                      ratio_ok;

    assign best_x5   = {3'b000, s4_best_reg} + {1'b0, s4_best_reg, 2'b00};
    assign second_x3 = {3'b000, s4_second_reg} + {2'b00, s4_second_reg, 1'b0};
    assign ratio_ok  = best_x5 < second_x3;

    logic                      m_valid_reg;
    logic                      m_matched_reg;
    logic [INDEX_W-1:0]        m_index_reg;

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            partial_reg   <= '0;
            qsign_reg     <= 1'b0;
            model_cnt_reg <= '0;
            best_reg      <= dnnr_pkg::DIST_INIT;
            second_reg    <= dnnr_pkg::DIST_INIT;
            best_pos_reg  <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg;
            // only query loads and model ends reach the compare stage
            s3_valid_reg  <= s2_valid_reg
                             && (s2_cmd_reg == dnnr_pkg::CMD_QUERY || s2_last_reg);
            s4_valid_reg  <= res_load;
            m_valid_reg   <= s4_valid_reg;
            partial_reg   <= partial_next;
            qsign_reg     <= qsign_next;
            model_cnt_reg <= model_cnt_next;
            best_reg      <= best_next;
            second_reg    <= second_next;
            best_pos_reg  <= best_pos_next;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_cmd_reg    <= in_cmd;
            s1_val_reg    <= s_tdata[ELEM_W-1:0];
            s1_sign_reg   <= s_tdata[ELEM_W];
            s1_final_reg  <= s_tlast;
            s1_last_reg   <= in_last;

            s2_cmd_reg    <= s1_cmd_reg;
            s2_sign_reg   <= s1_sign_reg;
            s2_final_reg  <= s1_final_reg;
            s2_last_reg   <= s1_last_reg;
            s2_sq_reg     <= prod[SQ_W-1:0];

            s3_clear_reg  <= (s2_cmd_reg == dnnr_pkg::CMD_QUERY);
            s3_sign_reg   <= s2_sign_reg;
            s3_final_reg  <= s2_final_reg;
            s3_dist_reg   <= sum;

            s4_best_reg   <= upd_best;
            s4_second_reg <= upd_second;
            s4_pos_reg    <= upd_pos;

            m_matched_reg <= ratio_ok;
            m_index_reg   <= ratio_ok ? s4_pos_reg : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_matched_reg;
    assign m_tdata  = m_index_reg;

endmodule

`default_nettype wire

/* sv/dnnr_checker.sv */
// ----------------------------------------------------------------------------
// dnnr_checker
// Port-level checks of the descriptor nearest neighbor ratio block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "descriptor_nearest_neighbor_ratio_defines.svh"

module dnnr_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [dnnr_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic                            m_tuser
);

    // hold a stalled result
    `DNNR_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // no-match results carry index zero
    `DNNR_ASSERT_NOW(a_nomatch_zero, clk, rst_n, m_tvalid && !m_tuser, m_tdata == '0)

    // input side stalls only behind a waiting result
    `DNNR_ASSERT_NOW(a_ready_free, clk, rst_n, !m_tvalid || m_tready, s_tready)

    // a waiting result blocks the input
    `DNNR_ASSERT_NOW(a_ready_block, clk, rst_n, m_tvalid && !m_tready && s_tvalid, !s_tready)

endmodule

bind descriptor_nearest_neighbor_ratio dnnr_checker u_dnnr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

/* dv/descriptor_nearest_neighbor_ratio_tb.sv */
// ----------------------------------------------------------------------------
// descriptor_nearest_neighbor_ratio_tb
// Self-checking bench for the nearest neighbor ratio search. Query and model
// descriptors stream in under random idling on both sides. A scoreboard keeps
// its own copy of the search state, predicts each ratio-test result and
// compares it field by field with what the block delivers. Several descriptor
// lengths are used, including out-of-range register values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module descriptor_nearest_neighbor_ratio_tb;

    localparam int ELEM_W     = dnnr_pkg::ELEM_W;
    localparam int DIST_W     = dnnr_pkg::DIST_W;
    localparam int INDEX_W    = dnnr_pkg::INDEX_W;
    localparam int LEN_W      = dnnr_pkg::LEN_W;
    localparam int MAX_LENGTH = dnnr_pkg::MAX_LENGTH;
    localparam int S_TDATA_W  = dnnr_pkg::S_TDATA_W;
    localparam int M_TDATA_W  = dnnr_pkg::M_TDATA_W;

    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int NUM_PHASES   = 9;

    typedef struct packed {
        bit               matched;
        bit [INDEX_W-1:0] index;
    } match_t;

    class nn_ratio_board;
        logic [ELEM_W-1:0] query_mem [MAX_LENGTH];
        bit                query_sign;
        int unsigned       elem_pos;
        int unsigned       model_idx;
        int unsigned       best_idx;
        int unsigned       length_reg;
        bit [DIST_W-1:0]   partial;
        bit [DIST_W-1:0]   best;
        bit [DIST_W-1:0]   second;
        match_t            pending [$];
        int unsigned       results_checked;
        int unsigned       errors;

        function new();
            foreach (query_mem[i])
                query_mem[i] = '0;
            query_sign      = 1'b0;
            elem_pos        = 0;
            length_reg      = dnnr_pkg::LEN_RESET;
            results_checked = 0;
            errors          = 0;
            clear_search();
        endfunction

        function void clear_search();
            model_idx = 0;
            partial   = '0;
            best      = dnnr_pkg::DIST_INIT;
            second    = dnnr_pkg::DIST_INIT;
            best_idx  = 0;
        endfunction

        function void write_length(bit [LEN_W-1:0] value);
            length_reg = value;
        endfunction

        function int unsigned eff_len();
            int unsigned n;
            n = length_reg;
            if (n < dnnr_pkg::MIN_LEN)
                n = dnnr_pkg::MIN_LEN;
            if (n > dnnr_pkg::MAX_LEN)
                n = dnnr_pkg::MAX_LEN;
            return n;
        endfunction

        function int unsigned next_pos();
            return (elem_pos >= eff_len()) ? 0 : elem_pos;
        endfunction

        function void accept_element(dnnr_pkg::cmd_t cmd, logic [ELEM_W-1:0] value, bit sign,
                                     bit fin);
            int unsigned len;
            int unsigned p;
            bit          last;
            longint      diff;
            bit [63:0]   lhs;
            bit [63:0]   rhs;
            match_t      res;
            len      = eff_len();
            p        = next_pos();
            last     = (p + 1 >= len);
            elem_pos = last ? 0 : p + 1;
            if (cmd == dnnr_pkg::CMD_QUERY)
            begin
                query_mem[p] = value;
                query_sign   = sign;
                clear_search();
                return;
            end
            diff    = longint'($signed(query_mem[p])) - longint'($signed(value));
            partial = partial + DIST_W'(diff * diff);
            if (!last)
                return;
            if (sign == query_sign)
            begin
                if (partial < best)
                begin
                    second   = best;
                    best     = partial;
                    best_idx = model_idx;
                end
                else if (partial < second)
                begin
                    second = partial;
                end
            end
            partial   = '0;
            model_idx = (model_idx + 1) % 65536;
            if (!fin)
                return;
            lhs         = 64'(best) * 64'd5;
            rhs         = 64'(second) * 64'd3;
            res.matched = (lhs < rhs);
            res.index   = res.matched ? INDEX_W'(best_idx) : '0;
            pending     = {pending, res};
            clear_search();
        endfunction

        function void check_match(bit matched, bit [INDEX_W-1:0] index);
            match_t exp_res;
            results_checked++;
            if (pending.size() == 0)
            begin
                $error("unexpected result: matched %0d neighbor_index %0d", matched, index);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            if (matched !== exp_res.matched)
            begin
                $error("matched: expected %0d, actual %0d", exp_res.matched, matched);
                errors++;
            end
            if (index !== exp_res.index)
            begin
                $error("neighbor_index: expected %0d, actual %0d", exp_res.index, index);
                errors++;
            end
        endfunction
    endclass

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [LEN_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 s_tuser     = 1'b0;
    logic                 s_tlast     = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    nn_ratio_board board = new();
    bit            quiet_tail = 1'b0;
    int unsigned   items_sent = 0;

    descriptor_nearest_neighbor_ratio u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic [ELEM_W-1:0] rand_element();
        int v;
        case ($urandom_range(0, 9))
            0:       v = 16384;
            1:       v = -16384;
            2:       v = 0;
            default: v = int'($urandom_range(0, 32768)) - 16384;
        endcase
        return v[ELEM_W-1:0];
    endfunction

    function automatic logic [ELEM_W-1:0] near_element(logic [ELEM_W-1:0] base, int spread);
        int v;
        v = int'($signed(base)) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > 16384)
            v = 16384;
        if (v < -16384)
            v = -16384;
        return v[ELEM_W-1:0];
    endfunction

    task automatic drive_item(dnnr_pkg::cmd_t cmd, logic [ELEM_W-1:0] value, bit sign, bit fin);
        int gap;
        gap = 0;
        if (!quiet_tail && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 4);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {{(S_TDATA_W-ELEM_W-1){1'b0}}, sign, value};
        s_tuser  = cmd;
        s_tlast  = fin;
        do
            @(posedge clk);
        while (!s_tready);
        board.accept_element(cmd, value, sign, fin);
        items_sent++;
    endtask

    // Write the length only once every pending result is out and the pipe is quiet.
    task automatic set_length(bit [LEN_W-1:0] value);
        @(negedge clk);
        s_tvalid = 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        board.write_length(value);
    endtask

    // spread < 0 draws a random model, otherwise a model near the stored query.
    task automatic send_model(int unsigned len, bit qsign, bit fin, int spread, bit noisy);
        int unsigned       p;
        int                abort_at;
        logic [ELEM_W-1:0] v;
        bit                sgn;
        bit                tl;
        abort_at = -1;
        if (noisy && $urandom_range(0, 11) == 0)
            abort_at = int'($urandom_range(0, len - 1));
        for (int i = 0; i < len; i++)
        begin
            if (i == abort_at)
                drive_item(dnnr_pkg::CMD_QUERY, rand_element(), 1'($urandom_range(0, 1)), 1'b0);
            p = board.next_pos();
            v = (spread < 0) ? rand_element() : near_element(board.query_mem[p], spread);
            if (i == len - 1)
            begin
                sgn = (noisy && $urandom_range(0, 6) == 0) ? !qsign : qsign;
                tl  = fin;
            end
            else
            begin
                sgn = 1'($urandom_range(0, 1));
                tl  = noisy && ($urandom_range(0, 4) == 0);
            end
            drive_item(dnnr_pkg::CMD_MODEL, v, sgn, tl);
        end
    endtask

    task automatic send_set();
        int unsigned len;
        int unsigned nmodels;
        bit          qs;
        int          spread;
        len = board.eff_len();
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 6))
                drive_item(dnnr_pkg::cmd_t'($urandom_range(0, 1)), rand_element(),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        // realign so that the query load starts at element zero
        while (board.next_pos() != 0)
            drive_item(dnnr_pkg::CMD_QUERY, rand_element(), 1'($urandom_range(0, 1)), 1'b0);
        qs = 1'($urandom_range(0, 1));
        for (int i = 0; i < len; i++)
            drive_item(dnnr_pkg::CMD_QUERY, rand_element(), qs, 1'b0);
        if (len > 32)
            nmodels = $urandom_range(1, 2);
        else if ($urandom_range(0, 9) == 0)
            nmodels = $urandom_range(5, 8);
        else
            nmodels = $urandom_range(1, 4);
        for (int m = 0; m < nmodels; m++)
        begin
            case ($urandom_range(0, 4))
                0:       spread = 0;
                1:       spread = 16;
                2:       spread = 1000;
                default: spread = -1;
            endcase
            send_model(len, qs, m == nmodels - 1, spread, 1'b1);
        end
    endtask

    // Receiver: random back-pressure, one long hold-off while a result waits.
    initial
    begin
        int low_left;
        int hold_left;
        bit hold_done;
        low_left  = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (quiet_tail)
            begin
                m_tready = 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                m_tready = 1'b0;
            end
            else if (!hold_done && board.results_checked >= 5 && m_tvalid)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_tready  = 1'b0;
            end
            else if (low_left > 0)
            begin
                low_left--;
                m_tready = 1'b0;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                low_left = $urandom_range(1, 4) - 1;
                m_tready = 1'b0;
            end
            else
            begin
                m_tready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_match(m_tuser, m_tdata);
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("descriptor_nearest_neighbor_ratio: mismatch");
        $finish;
    end

    initial
    begin
        bit [LEN_W-1:0] phase_len   [NUM_PHASES];
        int unsigned    phase_items [NUM_PHASES];
        bit             qs;
        int unsigned    target;
        phase_len   = '{8'd4, 8'd8, 8'd0, 8'd7, 8'd12, 8'd255, 8'd16, 8'd2, 8'd4};
        phase_items = '{200, 200, 150, 150, 150, 250, 150, 100, 250};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Run one set at the reset length, then fill the whole query store.
        qs = 1'($urandom_range(0, 1));
        for (int i = 0; i < board.eff_len(); i++)
            drive_item(dnnr_pkg::CMD_QUERY, rand_element(), qs, 1'b0);
        send_model(board.eff_len(), qs, 1'b1, -1, 1'b0);
        set_length(8'd128);
        for (int i = 0; i < MAX_LENGTH; i++)
            drive_item(dnnr_pkg::CMD_QUERY, rand_element(), 1'($urandom_range(0, 1)), 1'b0);

        set_length(8'd4);
        // exact copy beats a far model; signs of inner elements do not matter
        drive_item(dnnr_pkg::CMD_QUERY, 16'h4000, 1'b1, 1'b0);
        drive_item(dnnr_pkg::CMD_QUERY, 16'hC000, 1'b1, 1'b0);
        drive_item(dnnr_pkg::CMD_QUERY, 16'h0000, 1'b1, 1'b0);
        drive_item(dnnr_pkg::CMD_QUERY, 16'hFFFF, 1'b1, 1'b0);
        send_model(4, 1'b1, 1'b0, 0, 1'b0);
        for (int i = 0; i < 4; i++)
            drive_item(dnnr_pkg::CMD_MODEL, (i % 2) ? 16'h4000 : 16'hC000, 1'b1, i == 3);
        // no model carries the query sign: no match
        drive_item(dnnr_pkg::CMD_QUERY, 16'h1FFF, 1'b0, 1'b0);
        drive_item(dnnr_pkg::CMD_QUERY, 16'hE000, 1'b0, 1'b0);
        drive_item(dnnr_pkg::CMD_QUERY, 16'h0002, 1'b0, 1'b0);
        drive_item(dnnr_pkg::CMD_QUERY, 16'h0001, 1'b0, 1'b0);
        for (int m = 0; m < 2; m++)
        begin
            for (int i = 0; i < 4; i++)
                drive_item(dnnr_pkg::CMD_MODEL, rand_element(), i == 3, m == 1 && i == 3);
        end

        for (int k = 0; k < NUM_PHASES; k++)
        begin
            set_length(phase_len[k]);
            quiet_tail = (k == NUM_PHASES - 1);
            target     = items_sent + phase_items[k];
            while (items_sent < target)
                send_set();
        end

        @(negedge clk);
        s_tvalid = 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (board.errors == 0)
            $display("descriptor_nearest_neighbor_ratio: match");
        else
            $display("descriptor_nearest_neighbor_ratio: mismatch");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/dnnr_pkg.sv
sv/dnnr_ram.sv
sv/descriptor_nearest_neighbor_ratio.sv
sv/dnnr_checker.sv
dv/descriptor_nearest_neighbor_ratio_tb.sv
